// ===== hw/rtl/csl_pkg.sv =====
// csl_pkg: shared types, constants and helper functions for the c subset lexer
// scan mode enum, token classes, error codes, character codes, keyword lookup
// no dependencies
package csl_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int KEYWORD_BYTES_DEF = 8;
  localparam int KW_CMP_BYTES      = 8;
  localparam int LINE_W            = 24;

  localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_INT    = 3'd2,
    MODE_FLOAT  = 3'd3,
    MODE_STRING = 3'd4,
    MODE_LINEC  = 3'd5,
    MODE_BLOCKC = 3'd6,
    MODE_PEND   = 3'd7
  } scan_mode_t;

  typedef logic [KW_CMP_BYTES-1:0][7:0] kw_word_t;

  localparam logic       KIND_TOKEN = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;

  localparam logic [4:0] TC_IDENT    = 5'd0;
  localparam logic [4:0] TC_BOOLEAN  = 5'd1;
  localparam logic [4:0] TC_BREAK    = 5'd2;
  localparam logic [4:0] TC_CONTINUE = 5'd3;
  localparam logic [4:0] TC_ELSE     = 5'd4;
  localparam logic [4:0] TC_FOR      = 5'd5;
  localparam logic [4:0] TC_FLOATKW  = 5'd6;
  localparam logic [4:0] TC_IF       = 5'd7;
  localparam logic [4:0] TC_INTKW    = 5'd8;
  localparam logic [4:0] TC_RETURN   = 5'd9;
  localparam logic [4:0] TC_VOID     = 5'd10;
  localparam logic [4:0] TC_WHILE    = 5'd11;
  localparam logic [4:0] TC_BOOL     = 5'd12;
  localparam logic [4:0] TC_INT      = 5'd13;
  localparam logic [4:0] TC_FLOAT    = 5'd14;
  localparam logic [4:0] TC_STRING   = 5'd15;
  localparam logic [4:0] TC_ADD      = 5'd16;
  localparam logic [4:0] TC_MUL      = 5'd17;
  localparam logic [4:0] TC_REL      = 5'd18;
  localparam logic [4:0] TC_EQU      = 5'd19;
  localparam logic [4:0] TC_LOGIC    = 5'd20;
  localparam logic [4:0] TC_ASSIGN   = 5'd21;
  localparam logic [4:0] TC_SEP      = 5'd22;

  localparam logic [1:0] ERR_FLOAT   = 2'd0;
  localparam logic [1:0] ERR_BAR     = 2'd1;
  localparam logic [1:0] ERR_AMP     = 2'd2;
  localparam logic [1:0] ERR_UNEXP   = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == CH_UNDER) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_LOWER_E) || (c == CH_UPPER_E);
  endfunction

  function automatic scan_mode_t start_mode(input logic [7:0] c);
    scan_mode_t m;
    if (is_space(c)) begin
      m = MODE_START;
    end else if (is_alpha(c)) begin
      m = MODE_IDENT;
    end else if (is_digit(c)) begin
      m = MODE_INT;
    end else if (c == CH_QUOTE) begin
      m = MODE_STRING;
    end else if (c == CH_DOT) begin
      m = MODE_FLOAT;
    end else begin
      m = MODE_PEND;
    end
    return m;
  endfunction

  // keyword lookup over the first bytes of a word, right-justified for compare
  function automatic logic [4:0] word_class(input kw_word_t w, input logic [7:0] len);
    logic [8*KW_CMP_BYTES-1:0] rj;
    logic [4:0]                cls;
    rj = '0;
    for (int i = 0; i < KW_CMP_BYTES; i++) begin
      if (len > 8'(i)) begin
        rj = {rj[8*KW_CMP_BYTES-9:0], w[i]};
      end
    end
    cls = TC_IDENT;
    if (len == 8'd7 && rj == 64'("boolean")) cls = TC_BOOLEAN;
    else if (len == 8'd5 && rj == 64'("break")) cls = TC_BREAK;
    else if (len == 8'd8 && rj == 64'("continue")) cls = TC_CONTINUE;
    else if (len == 8'd4 && rj == 64'("else")) cls = TC_ELSE;
    else if (len == 8'd3 && rj == 64'("for")) cls = TC_FOR;
    else if (len == 8'd5 && rj == 64'("float")) cls = TC_FLOATKW;
    else if (len == 8'd2 && rj == 64'("if")) cls = TC_IF;
    else if (len == 8'd3 && rj == 64'("int")) cls = TC_INTKW;
    else if (len == 8'd6 && rj == 64'("return")) cls = TC_RETURN;
    else if (len == 8'd4 && rj == 64'("void")) cls = TC_VOID;
    else if (len == 8'd5 && rj == 64'("while")) cls = TC_WHILE;
    else if (len == 8'd4 && rj == 64'("true")) cls = TC_BOOL;
    else if (len == 8'd5 && rj == 64'("false")) cls = TC_BOOL;
    return cls;
  endfunction

endpackage

// ===== hw/rtl/c_subset_lexer_dfa_top.sv =====
// c_subset_lexer_dfa_top: byte-serial lexer dfa with a registered result stage
// result registered in the cycle after its byte transaction; throughput 1 byte per cycle while char_stall is low
// next-state and event logic sit between the scanner registers and the result register
// rst (synchronous) returns to start mode, line count 1, no result pending
// the word buffer holds no reset value; depends on csl_pkg
module c_subset_lexer_dfa_top #(
  parameter int MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF,
  parameter int KEYWORD_BYTES = csl_pkg::KEYWORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  logic [7:0]                  char_byte,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        result_kind,
  output logic [4:0]                  token_class,
  output logic [7:0]                  token_length,
  output logic [7:0]                  symbol,
  output logic [csl_pkg::LINE_W-1:0]  line_number,
  output logic [1:0]                  error_code
);
  import csl_pkg::*;

  localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;
  localparam int         IDX_W   = $clog2(KEYWORD_BYTES);

  scan_mode_t        mode, mode_next;
  logic [7:0]        previous_char, previous_char_next;
  logic [7:0]        text_length, text_length_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  logic [7:0]        word_buffer [KEYWORD_BYTES];

  logic              accept;
  logic [7:0]        b, p;
  logic [7:0]        len_grow;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              pend_used;
  kw_word_t          kw_word;

  logic              ev_valid, ev_kind;
  logic [4:0]        ev_class;
  logic [7:0]        ev_len, ev_sym;
  logic [1:0]        ev_code;

  assign char_stall = result_valid & result_stall;
  assign accept     = char_valid & ~char_stall;
  assign b          = char_byte;
  assign p          = previous_char;
  assign len_grow   = (text_length < LEN_CAP) ? text_length + 8'd1 : text_length;

  always_comb begin
    for (int i = 0; i < KW_CMP_BYTES; i++) begin
      kw_word[i] = word_buffer[i];
    end
  end

  always_comb begin
    if ((b == CH_CR || (b == CH_LF && p != CH_CR)) && line_count != LINE_TOP) begin
      line_count_next = line_count + 1'b1;
    end else begin
      line_count_next = line_count;
    end
  end

  assign pend_used = ((p == CH_EQ || p == CH_BANG || p == CH_LT || p == CH_GT) && b == CH_EQ) ||
                     (p == CH_BAR && b == CH_BAR) || (p == CH_AMP && b == CH_AMP) ||
                     (p == CH_SLASH && (b == CH_SLASH || b == CH_STAR));

  // next state
  always_comb begin
    mode_next          = mode;
    text_length_next   = text_length;
    previous_char_next = b;
    wr_en              = 1'b0;
    wr_idx             = '0;
    unique case (mode)
      MODE_START: begin
        mode_next        = start_mode(b);
        text_length_next = (start_mode(b) == MODE_START || start_mode(b) == MODE_PEND) ?
                           8'd0 : 8'd1;
        wr_en            = is_alpha(b);
      end
      MODE_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          text_length_next = len_grow;
          wr_en            = text_length < 8'(KEYWORD_BYTES);
          wr_idx           = text_length[IDX_W-1:0];
        end else begin
          mode_next = MODE_PEND;
        end
      end
      MODE_INT: begin
        if (is_digit(b) || b == CH_DOT || is_exp(b)) begin
          text_length_next = len_grow;
          if (!is_digit(b)) mode_next = MODE_FLOAT;
        end else begin
          mode_next = MODE_PEND;
        end
      end
      MODE_FLOAT: begin
        if (p == CH_DOT) begin
          if (is_digit(b)) text_length_next = len_grow;
          else mode_next = MODE_PEND;
        end else if (is_exp(p)) begin
          if (is_digit(b) || b == CH_PLUS || b == CH_MINUS) text_length_next = len_grow;
          else mode_next = MODE_START;
        end else if (is_digit(p)) begin
          if (is_digit(b) || is_exp(b)) text_length_next = len_grow;
          else mode_next = MODE_PEND;
        end else begin
          if (is_digit(b)) text_length_next = len_grow;
          else mode_next = MODE_START;
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE && p != CH_BSLASH) begin
          mode_next = MODE_START;
        end else if (b != CH_LF && b != CH_CR) begin
          text_length_next = len_grow;
        end
      end
      MODE_LINEC: begin
        if (b == CH_LF || b == CH_CR) mode_next = MODE_START;
      end
      MODE_BLOCKC: begin
        if (p == CH_STAR && b == CH_SLASH) mode_next = MODE_START;
      end
      MODE_PEND: begin
        if (pend_used) begin
          text_length_next = 8'd0;
          if (p == CH_SLASH && b == CH_SLASH) begin
            mode_next = MODE_LINEC;
          end else if (p == CH_SLASH && b == CH_STAR) begin
            mode_next          = MODE_BLOCKC;
            previous_char_next = 8'd0;
          end else begin
            mode_next = MODE_START;
          end
        end else begin
          mode_next        = start_mode(b);
          text_length_next = (start_mode(b) == MODE_START || start_mode(b) == MODE_PEND) ?
                             8'd0 : 8'd1;
          wr_en            = is_alpha(b);
        end
      end
      default: mode_next = MODE_START;
    endcase
  end

  // event for this byte
  always_comb begin
    ev_valid = 1'b0;
    ev_kind  = KIND_TOKEN;
    ev_class = TC_IDENT;
    ev_len   = 8'd0;
    ev_sym   = 8'd0;
    ev_code  = ERR_FLOAT;
    unique case (mode)
      MODE_IDENT: begin
        if (!(is_alpha(b) || is_digit(b))) begin
          ev_valid = 1'b1;
          ev_class = word_class(kw_word, text_length);
          ev_len   = text_length;
        end
      end
      MODE_INT: begin
        if (!(is_digit(b) || b == CH_DOT || is_exp(b))) begin
          ev_valid = 1'b1;
          ev_class = TC_INT;
          ev_len   = text_length;
        end
      end
      MODE_FLOAT: begin
        if ((p == CH_DOT && !is_digit(b)) ||
            (p != CH_DOT && !is_exp(p) && is_digit(p) && !is_digit(b) && !is_exp(b))) begin
          ev_valid = 1'b1;
          ev_class = TC_FLOAT;
          ev_len   = text_length;
        end else if ((is_exp(p) && !(is_digit(b) || b == CH_PLUS || b == CH_MINUS)) ||
                     (p != CH_DOT && !is_exp(p) && !is_digit(p) && !is_digit(b))) begin
          ev_valid = 1'b1;
          ev_kind  = KIND_ERROR;
          ev_sym   = b;
          ev_code  = ERR_FLOAT;
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE && p != CH_BSLASH) begin
          ev_valid = 1'b1;
          ev_class = TC_STRING;
          ev_len   = text_length;
        end
      end
      MODE_PEND: begin
        ev_valid = 1'b1;
        ev_sym   = p;
        ev_len   = pend_used ? 8'd2 : 8'd1;
        case (p)
          CH_SPACE, CH_TAB, CH_CR, CH_LF: ev_valid = 1'b0;
          CH_EQ:                          ev_class = pend_used ? TC_EQU : TC_ASSIGN;
          CH_BANG:                        ev_class = pend_used ? TC_EQU : TC_LOGIC;
          CH_LT, CH_GT:                   ev_class = TC_REL;
          CH_BAR, CH_AMP: begin
            if (pend_used) begin
              ev_class = TC_LOGIC;
            end else begin
              ev_kind = KIND_ERROR;
              ev_len  = 8'd0;
              ev_code = (p == CH_BAR) ? ERR_BAR : ERR_AMP;
            end
          end
          CH_SLASH: begin
            ev_valid = ~pend_used;
            ev_class = TC_MUL;
          end
          CH_STAR:                        ev_class = TC_MUL;
          CH_PLUS, CH_MINUS:              ev_class = TC_ADD;
          CH_LBRACE, CH_RBRACE, CH_LBRK, CH_RBRK,
          CH_LPAR, CH_RPAR, CH_COMMA, CH_SEMI: ev_class = TC_SEP;
          default: begin
            ev_kind = KIND_ERROR;
            ev_len  = 8'd0;
            ev_code = ERR_UNEXP;
          end
        endcase
      end
      default: ev_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_START;
      previous_char <= 8'd0;
      text_length   <= 8'd0;
      line_count    <= LINE_W'(1);
    end else if (accept) begin
      mode          <= mode_next;
      previous_char <= previous_char_next;
      text_length   <= text_length_next;
      line_count    <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      word_buffer[wr_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= ev_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_valid) begin
      result_kind  <= ev_kind;
      token_class  <= ev_class;
      token_length <= ev_len;
      symbol       <= ev_sym;
      line_number  <= line_count_next;
      error_code   <= ev_code;
    end
  end

endmodule
